// ----- design/f2p_pkg.sv -----
package f2p_pkg;

    localparam logic [1:0] FMT_S16 = 2'd0;
    localparam logic [1:0] FMT_S32 = 2'd1;
    localparam logic [1:0] FMT_FLT = 2'd2;

    localparam logic [1:0] DEPTH_16 = 2'd0;
    localparam logic [1:0] DEPTH_24 = 2'd1;
    localparam logic [1:0] DEPTH_32 = 2'd2;

    localparam logic [0:0] REG_FORMAT = 1'b0;
    localparam logic [0:0] REG_DEPTH  = 1'b1;

    localparam logic [31:0] ONE_BITS = 32'h3F80_0000;

    typedef enum logic [1:0] {
        MODE_S16,
        MODE_S24,
        MODE_S32,
        MODE_FLT
    } t_mode;

    typedef struct packed {
        logic  bad;
        t_mode mode;
    } t_ctrl;

endpackage

// ----- design/f2p_scale.sv -----
module f2p_scale (
    input  logic [31:0]   i_bits,
    input  f2p_pkg::t_ctrl i_ctrl,
    output logic [31:0]   o_word,
    output logic          o_rejected
);

    logic        neg;
    logic [30:0] mag;
    logic [7:0]  expo;
    logic [23:0] mant;
    logic [7:0]  k;
    logic [8:0]  s;
    logic [31:0] full_m1;
    logic [31:0] r;
    logic [55:0] shl;
    logic [24:0] rnd;
    logic [31:0] v;
    logic [31:0] san;

    always_comb begin
        if (i_bits[30:23] == 8'hFF) begin
            san = '0;
        end else if ({1'b0, i_bits[30:0]} > f2p_pkg::ONE_BITS) begin
            san = {i_bits[31], f2p_pkg::ONE_BITS[30:0]};
        end else begin
            san = i_bits;
        end
        neg  = san[31];
        mag  = san[30:0];
        expo = (mag[30:23] == 8'd0) ? 8'd1 : mag[30:23];
        mant = {(mag[30:23] != 8'd0), mag[22:0]};
        case (i_ctrl.mode)
            f2p_pkg::MODE_S16: k = 8'd15;
            f2p_pkg::MODE_S24: k = 8'd23;
            default:           k = 8'd31;
        endcase
        full_m1 = (32'h1 << k[4:0]) - 32'd1;
        s   = 9'd150 - {1'b0, expo} - {1'b0, k};
        shl = '0;
        rnd = '0;
        if (s[8] || s == 9'd0) begin
            shl = {32'd0, mant} << 5'((~s) + 9'd1);
            r   = shl[31:0];
        end else if (s > 9'd25) begin
            r = '0;
        end else begin
            rnd = ({1'b0, mant} + (25'd1 << 5'(s - 9'd1))) >> 5'(s);
            r   = {7'd0, rnd};
        end
        if ({1'b0, mag} >= f2p_pkg::ONE_BITS) begin
            v = neg ? ~full_m1 : full_m1;
        end else if (neg) begin
            v = (~r) + 32'd1;
        end else if (r > full_m1) begin
            v = full_m1;
        end else begin
            v = r;
        end
        o_rejected = i_ctrl.bad;
        if (i_ctrl.bad) begin
            o_word = '0;
        end else begin
            case (i_ctrl.mode)
                f2p_pkg::MODE_S16: o_word = {16'd0, v[15:0]};
                f2p_pkg::MODE_S24: o_word = {v[23:0], 8'd0};
                f2p_pkg::MODE_S32: o_word = v;
                default:           o_word = san;
            endcase
        end
    end

endmodule

// ----- design/float_to_pcm_encode.sv -----
// float_to_pcm_encode: converts IEEE-754 single-precision samples to PCM words.
// Input: pulse i_start with i_sample_bits while o_busy is low (o_busy is
// always low, so one sample per clock is taken).
// Config: i_cfg_valid/o_cfg_ready with i_cfg_index (0 format, 1 depth) and
// i_cfg_data; write only while no sample is in flight.
// Output: o_valid strobes for one cycle with o_pcm_word and o_rejected,
// registered through the input register and then the result register.
// Throughput is one sample per cycle; the path is a single clamp, shift and
// round between the two registers.
// NaN and infinity become +0.0, values clamp to [-1,1]; unsupported
// format/depth pairs report rejected with a zero word.
// Reset clears the strobes and sets format S16, depth 16.
// The receiver cannot stall; each result is valid for exactly one cycle.
module float_to_pcm_encode (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_sample_bits,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [1:0]  i_cfg_data,
    output logic        o_valid,
    output logic [31:0] o_pcm_word,
    output logic        o_rejected
);

    logic [1:0]     r_format;
    logic [1:0]     r_depth;
    logic           r_in_valid;
    logic [31:0]    r_in_bits;
    logic           r_out_valid;
    logic [31:0]    r_word;
    logic           r_rej;
    f2p_pkg::t_ctrl n_ctrl;
    logic [31:0]    n_word;
    logic           n_rej;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_ctrl.bad  = 1'b0;
        n_ctrl.mode = f2p_pkg::MODE_FLT;
        if (r_format == f2p_pkg::FMT_S16 && r_depth == f2p_pkg::DEPTH_16) begin
            n_ctrl.mode = f2p_pkg::MODE_S16;
        end else if (r_format == f2p_pkg::FMT_S32 && r_depth == f2p_pkg::DEPTH_24) begin
            n_ctrl.mode = f2p_pkg::MODE_S24;
        end else if (r_format == f2p_pkg::FMT_S32 && r_depth == f2p_pkg::DEPTH_32) begin
            n_ctrl.mode = f2p_pkg::MODE_S32;
        end else if (r_format == f2p_pkg::FMT_FLT && r_depth == f2p_pkg::DEPTH_32) begin
            n_ctrl.mode = f2p_pkg::MODE_FLT;
        end else begin
            n_ctrl.bad = 1'b1;
        end
    end

    f2p_scale u_scale (
        .i_bits     (r_in_bits),
        .i_ctrl     (n_ctrl),
        .o_word     (n_word),
        .o_rejected (n_rej)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format    <= f2p_pkg::FMT_S16;
            r_depth     <= f2p_pkg::DEPTH_16;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    f2p_pkg::REG_FORMAT: r_format <= i_cfg_data;
                    f2p_pkg::REG_DEPTH:  r_depth  <= i_cfg_data;
                    default: ;
                endcase
            end
            r_in_valid  <= i_start && !o_busy;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_bits <= i_sample_bits;
        r_word    <= n_word;
        r_rej     <= n_rej;
    end

    assign o_valid    = r_out_valid;
    assign o_pcm_word = r_word;
    assign o_rejected = r_rej;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> ##1 o_valid) else $error("result strobe missing");
    a_rej_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rejected |-> o_pcm_word == 32'd0) else $error("rejected word nonzero");
    a_s16_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !n_ctrl.bad && n_ctrl.mode == f2p_pkg::MODE_S16
        |=> o_pcm_word[31:16] == 16'd0) else $error("S16 high half nonzero");

endmodule

// ----- bench/float_to_pcm_encode_test.sv -----
module float_to_pcm_encode_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 1480;

    localparam logic [1:0] FMT_UNDEF   = 2'd3;
    localparam logic [1:0] DEPTH_UNDEF = 2'd3;

    typedef struct {
        logic [31:0] word;
        logic        rej;
    } t_pcm;

    typedef struct {
        logic [31:0] sample;
        logic        known;
        logic [31:0] word;
        logic        rej;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [31:0] i_sample_bits;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [1:0]  i_cfg_data;
    logic        o_valid;
    logic [31:0] o_pcm_word;
    logic        o_rejected;

    float_to_pcm_encode i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_sample_bits (i_sample_bits),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_pcm_word    (o_pcm_word),
        .o_rejected    (o_rejected)
    );

    logic [1:0] fmt_q;
    logic [1:0] depth_q;
    t_pcm       pending_pcm[$];
    int         mismatches;
    int         cycles;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] clean_sample(logic [31:0] b);
        if (b[30:23] == 8'hFF) return 32'h0;
        if (b[30:0] > f2p_pkg::ONE_BITS[30:0]) return {b[31], f2p_pkg::ONE_BITS[30:0]};
        return b;
    endfunction

    // saturated, rounded sample * 2^k as a 64-bit signed value
    function automatic longint scale_sample(logic [31:0] b, int k);
        longint full;
        longint mant;
        longint r;
        int     e;
        int     s;
        full = longint'(1) << k;
        if (b[30:0] >= f2p_pkg::ONE_BITS[30:0]) return b[31] ? -full : full - 1;
        e    = int'(b[30:23]);
        mant = longint'(b[22:0]);
        if (e == 0) e = 1;
        else mant = mant | 64'h80_0000;
        s = 150 - e - k;
        if (s <= 0) r = mant << (-s);
        else if (s > 25) r = 0;
        else r = (mant + (longint'(1) << (s - 1))) >>> s;
        if (b[31]) return -r;
        if (r > full - 1) return full - 1;
        return r;
    endfunction

    function automatic t_pcm encode_sample(logic [31:0] raw);
        t_pcm        p;
        logic [31:0] b;
        longint      v;
        b      = clean_sample(raw);
        p.word = '0;
        p.rej  = 1'b0;
        if (fmt_q == f2p_pkg::FMT_S16 && depth_q == f2p_pkg::DEPTH_16) begin
            v      = scale_sample(b, 15);
            p.word = {16'h0, v[15:0]};
        end else if (fmt_q == f2p_pkg::FMT_S32 && depth_q == f2p_pkg::DEPTH_24) begin
            v      = scale_sample(b, 23);
            p.word = {v[23:0], 8'h0};
        end else if (fmt_q == f2p_pkg::FMT_S32 && depth_q == f2p_pkg::DEPTH_32) begin
            v      = scale_sample(b, 31);
            p.word = v[31:0];
        end else if (fmt_q == f2p_pkg::FMT_FLT && depth_q == f2p_pkg::DEPTH_32) begin
            p.word = b;
        end else begin
            p.rej = 1'b1;
        end
        return p;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            if (pending_pcm.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected transaction: word %h rej %b", o_pcm_word, o_rejected);
            end else begin
                t_pcm e;
                e = pending_pcm.pop_front();
                if (e.word !== o_pcm_word || e.rej !== o_rejected) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected word %h rej %b, got word %h rej %b",
                                 e.word, e.rej, o_pcm_word, o_rejected);
                end
            end
        end
    end

    task automatic idle_cycles(int n);
        repeat (n) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_pcm.size() != 0) @(negedge i_clk);
        idle_cycles(4);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == f2p_pkg::REG_FORMAT) fmt_q = data;
        else depth_q = data;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_mode(logic [1:0] f, logic [1:0] d);
        wait_drained();
        write_reg(f2p_pkg::REG_FORMAT, f);
        write_reg(f2p_pkg::REG_DEPTH, d);
    endtask

    // called at a falling edge; returns after the accepting rising edge
    task automatic send_sample(logic [31:0] s, int gap, output t_pcm p);
        if (gap > 0) begin
            i_start <= 1'b0;
            idle_cycles(gap);
        end
        i_start       <= 1'b1;
        i_sample_bits <= s;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        p = encode_sample(s);
        pending_pcm.push_back(p);
        @(negedge i_clk);
    endtask

    task automatic stop_sending();
        i_start <= 1'b0;
    endtask

    function automatic logic [31:0] random_sample();
        logic [31:0] s;
        int          pick;
        pick = $urandom_range(0, 9);
        s    = $urandom();
        case (pick)
            0: s[30:23] = 8'hFF;
            1: s[30:23] = 8'h00;
            2: s[30:0]  = 31'(f2p_pkg::ONE_BITS[30:0] + $urandom_range(0, 3) - 1);
            3, 4: s[30:23] = 8'($urandom_range(100, 126));
            5: s[30:23] = 8'($urandom_range(127, 130));
            6: s[30:23] = 8'd126;
            default: ;
        endcase
        return s;
    endfunction

    t_row table_rows[] = '{
        '{32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
        '{32'h8000_0000, 1'b1, 32'h0000_0000, 1'b0},
        '{32'h3F80_0000, 1'b1, 32'h0000_7FFF, 1'b0},
        '{32'hBF80_0000, 1'b1, 32'h0000_8000, 1'b0},
        '{32'h7F80_0000, 1'b1, 32'h0000_0000, 1'b0},
        '{32'hFF80_0000, 1'b1, 32'h0000_0000, 1'b0},
        '{32'h7FC0_0000, 1'b1, 32'h0000_0000, 1'b0},
        '{32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
        '{32'h7F7F_FFFF, 1'b1, 32'h0000_7FFF, 1'b0},
        '{32'hFF7F_FFFF, 1'b1, 32'h0000_8000, 1'b0},
        '{32'h3F00_0000, 1'b1, 32'h0000_4000, 1'b0},
        '{32'h3F7F_FFFF, 1'b0, 32'h0, 1'b0},
        '{32'h0000_0001, 1'b0, 32'h0, 1'b0},
        '{32'h807F_FFFF, 1'b0, 32'h0, 1'b0},
        '{32'h3800_0000, 1'b0, 32'h0, 1'b0},
        '{32'hB800_0000, 1'b0, 32'h0, 1'b0},
        '{32'h3F80_0001, 1'b0, 32'h0, 1'b0},
        '{32'h5555_5555, 1'b0, 32'h0, 1'b0},
        '{32'hAAAA_AAAA, 1'b0, 32'h0, 1'b0}
    };

    logic [1:0] mode_list[8][2] = '{
        '{f2p_pkg::FMT_S32, f2p_pkg::DEPTH_24}, '{f2p_pkg::FMT_S32, f2p_pkg::DEPTH_32},
        '{f2p_pkg::FMT_FLT, f2p_pkg::DEPTH_32}, '{f2p_pkg::FMT_S16, f2p_pkg::DEPTH_24},
        '{FMT_UNDEF, DEPTH_UNDEF}, '{f2p_pkg::FMT_FLT, f2p_pkg::DEPTH_16},
        '{f2p_pkg::FMT_S32, DEPTH_UNDEF}, '{f2p_pkg::FMT_S16, f2p_pkg::DEPTH_16}
    };

    initial begin
        t_pcm p;
        int   phase;
        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_sample_bits = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        fmt_q         = f2p_pkg::FMT_S16;
        depth_q       = f2p_pkg::DEPTH_16;
        mismatches    = 0;
        cycles        = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (table_rows[r]) begin
            send_sample(table_rows[r].sample, (r % 3 == 0) ? 0 : $urandom_range(0, 3), p);
            if (table_rows[r].known &&
                (p.word !== table_rows[r].word || p.rej !== table_rows[r].rej)) begin
                mismatches++;
                $display("prediction disagrees with table row %0d", r);
            end
        end
        stop_sending();

        for (phase = 0; phase < 8; phase++) begin
            set_mode(mode_list[phase][0], mode_list[phase][1]);
            @(negedge i_clk);
            foreach (table_rows[r]) send_sample(table_rows[r].sample, 0, p);
            for (int n = 0; n < N_RANDOM / 8; n++) begin
                int gap;
                if (n == 40) begin
                    stop_sending();
                    while (pending_pcm.size() != 0) @(negedge i_clk);
                end
                gap = ((n / 64) % 2 == 0) ? 0 : $urandom_range(0, 15);
                send_sample(random_sample(), gap, p);
            end
            stop_sending();
        end

        wait_drained();
        idle_cycles(6);
        if (mismatches == 0 && pending_pcm.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d outstanding", mismatches, pending_pcm.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
design/f2p_pkg.sv
design/f2p_scale.sv
design/float_to_pcm_encode.sv
bench/float_to_pcm_encode_test.sv
